>>> sv/gbsfh_pkg.sv
// Shared types, constants and helper functions of the group-by-size fill histogram.
// Depends on nothing; every other file of the block refers to it by scoped names.
package gbsfh_pkg;

   localparam int MAX_GROUPS = 64;
   localparam int SLOT_W     = $clog2(MAX_GROUPS);
   localparam int USED_W     = SLOT_W + 1;
   localparam int NUM_BINS   = 10;
   localparam int LAST_BIN   = NUM_BINS - 1;
   localparam int BIN_W      = 4;
   localparam int BIN_ADDR_W = $clog2(MAX_GROUPS * NUM_BINS);
   localparam int KEY_W      = 8;
   localparam int COUNT_W    = 16;
   localparam int FILL_W     = 17;
   localparam int FRAC_W     = 16;
   localparam int OP_W       = 2;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   localparam logic [OP_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [OP_W-1:0] KIND_READ  = 2'd1;
   localparam logic [OP_W-1:0] KIND_CLEAR = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [KEY_W-1:0]  item_width;
      logic [KEY_W-1:0]  item_height;
      logic [FILL_W-1:0] fill_fraction;
      logic [SLOT_W-1:0] entry_index;
   } req_word_type;

   typedef struct packed {
      logic [OP_W-1:0]    result_kind;
      logic [SLOT_W-1:0]  group_slot;
      logic               is_new_group;
      logic               table_full;
      logic [KEY_W-1:0]   group_width;
      logic [KEY_W-1:0]   group_height;
      logic [COUNT_W-1:0] group_total;
      logic [BIN_W-1:0]   bin_number;
      logic [COUNT_W-1:0] bin_total;
      logic [USED_W-1:0]  groups_used;
      logic               entry_valid;
      logic               last_row;
   } rsp_word_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key_width;
      logic [KEY_W-1:0]   key_height;
      logic [COUNT_W-1:0] count;
   } entry_word_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [SLOT_W-1:0] addr;
      entry_word_type    wdata;
   } entry_cmd_type;

   typedef struct packed {
      logic                  rd_en;
      logic                  wr_en;
      logic [BIN_ADDR_W-1:0] addr;
      logic [COUNT_W-1:0]    wdata;
   } bin_cmd_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // min(9, floor(10 * fill)) with fill in unsigned 1.16 form
   function automatic logic [BIN_W-1:0] fill_bin(input logic [FILL_W-1:0] fill);
      logic [FILL_W+3:0] scaled;
      logic [4:0]        whole;
      scaled = ({4'b0000, fill} << 3) + ({4'b0000, fill} << 1);
      whole  = scaled[FILL_W+3:FRAC_W];
      return (whole > 5'(LAST_BIN)) ? BIN_W'(LAST_BIN) : whole[BIN_W-1:0];
   endfunction

   // first bin address of a slot: slot * 10
   function automatic logic [BIN_ADDR_W-1:0] bin_base(input logic [SLOT_W-1:0] slot);
      return (BIN_ADDR_W'(slot) << 3) + (BIN_ADDR_W'(slot) << 1);
   endfunction

endpackage

>>> sv/gbsfh_stream_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on gbsfh_pkg for the payload types.
interface gbsfh_req_if;
   logic                    valid;
   logic                    ready;
   gbsfh_pkg::req_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface gbsfh_rsp_if;
   logic                    valid;
   logic                    ready;
   gbsfh_pkg::rsp_word_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> sv/gbsfh_entry_ram.sv
// Entry memory: key and group count of every slot, one port, registered read.
// Depends on gbsfh_pkg.
module gbsfh_entry_ram (
   input  logic                      clock,
   input  gbsfh_pkg::entry_cmd_type  cmd,
   output gbsfh_pkg::entry_word_type rd_data
);
   gbsfh_pkg::entry_word_type mem [gbsfh_pkg::MAX_GROUPS];
   gbsfh_pkg::entry_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      // hold the last read word until the next read
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/gbsfh_bin_ram.sv
// Fill bin memory: ten saturating counters per slot, one port, registered read.
// Depends on gbsfh_pkg.
module gbsfh_bin_ram (
   input  logic                            clock,
   input  gbsfh_pkg::bin_cmd_type          cmd,
   output logic [gbsfh_pkg::COUNT_W-1:0]   rd_data
);
   logic [gbsfh_pkg::COUNT_W-1:0] mem [gbsfh_pkg::MAX_GROUPS * gbsfh_pkg::NUM_BINS];
   logic [gbsfh_pkg::COUNT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> sv/group_by_size_fill_histogram_core.sv
// Group-by-size fill histogram core: sequencer, output register and assertions.
// Depends on gbsfh_pkg, gbsfh_stream_if, gbsfh_entry_ram and gbsfh_bin_ram.
//
// Usage
//   req carries one command word: add an item (key = width, height; fill ratio),
//   read the ten fill bins of one slot, or clear the table. Opcode 3 is dropped.
//   rsp returns one word per add or clear and ten words per read; last_row
//   marks the final word of each command.
// Timing
//   One command is in flight at a time; req.ready is high only while the
//   sequencer is idle. An add scans the used slots through the entry memory at
//   one slot per cycle. A hit bumps the group count and then rewrites the
//   chosen bin; a miss with room left allocates the next free slot and sweeps
//   its ten bins to initialise them; a miss on a full table reports it full.
//   A read fetches each bin row in turn through the bin memory port and then
//   emits it; a clear emits its single word and empties the table.
// Output and stalls
//   Every word lands in an output register; a finished word may wait there
//   while the next command is accepted. While it is full and rsp.ready is low,
//   the sequencer holds at its next word and the memories keep their read data.
// Reset
//   Synchronous, active high: the table becomes empty (no group in use) and
//   the output register empties. The memories are not swept; slots beyond
//   the used count are never reported.
module group_by_size_fill_histogram_core (
   input logic         clock,
   input logic         reset,
   gbsfh_req_if.sink   req,
   gbsfh_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_BIN_UPD,
      ST_FILL,
      ST_RD_BIN,
      ST_RD_OUT,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [gbsfh_pkg::OP_W-1:0]        op_ff, op_in;
   logic [gbsfh_pkg::KEY_W-1:0]       w_ff, w_in;
   logic [gbsfh_pkg::KEY_W-1:0]       h_ff, h_in;
   logic [gbsfh_pkg::BIN_W-1:0]       bin_ff, bin_in;
   logic [gbsfh_pkg::SLOT_W-1:0]      idx_ff, idx_in;
   logic                              rd_valid_ff, rd_valid_in;
   logic [gbsfh_pkg::USED_W-1:0]      used_ff, used_in;
   logic [gbsfh_pkg::USED_W-1:0]      scan_ff, scan_in;
   logic                              pend_ff, pend_in;
   logic [gbsfh_pkg::SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic [gbsfh_pkg::SLOT_W-1:0]      slot_ff, slot_in;
   logic [gbsfh_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [gbsfh_pkg::BIN_W-1:0]       sweep_ff, sweep_in;
   gbsfh_pkg::rsp_word_type           res_ff, res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   gbsfh_pkg::rsp_word_type           rsp_data_ff, rsp_data_in;

   gbsfh_pkg::entry_cmd_type          entry_cmd;
   gbsfh_pkg::entry_word_type         ent_rd;
   gbsfh_pkg::bin_cmd_type            bin_cmd;
   logic [gbsfh_pkg::COUNT_W-1:0]     bin_rd;
   logic [gbsfh_pkg::COUNT_W-1:0]     bin_new;
   logic                              out_free;
   logic                              key_hit;
   logic                              req_ready;

   gbsfh_entry_ram u_entry_ram (
      .clock   (clock),
      .cmd     (entry_cmd),
      .rd_data (ent_rd)
   );

   gbsfh_bin_ram u_bin_ram (
      .clock   (clock),
      .cmd     (bin_cmd),
      .rd_data (bin_rd)
   );

   // output register may take a new word when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req_ready = (state_ff == ST_IDLE);
   // compare the entry read in the previous cycle against the item key
   assign key_hit   = pend_ff && (ent_rd.key_width == w_ff) && (ent_rd.key_height == h_ff);
   assign bin_new   = gbsfh_pkg::sat_inc(bin_rd);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      bin_in       = bin_ff;
      idx_in       = idx_ff;
      rd_valid_in  = rd_valid_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      sweep_in     = sweep_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      entry_cmd    = '0;
      bin_cmd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               op_in       = req.payload.opcode;
               w_in        = req.payload.item_width;
               h_in        = req.payload.item_height;
               bin_in      = gbsfh_pkg::fill_bin(req.payload.fill_fraction);
               idx_in      = req.payload.entry_index;
               rd_valid_in = ({1'b0, req.payload.entry_index} < used_ff);
               scan_in     = '0;
               pend_in     = 1'b0;
               sweep_in    = '0;
               case (req.payload.opcode)
                  gbsfh_pkg::OP_ADD: begin
                     state_in = ST_SEARCH;
                  end
                  gbsfh_pkg::OP_READ: begin
                     // fetch the key and count; they stay in the read register
                     entry_cmd.rd_en = 1'b1;
                     entry_cmd.addr  = req.payload.entry_index;
                     state_in        = ST_RD_BIN;
                  end
                  gbsfh_pkg::OP_CLEAR: begin
                     res_in             = '0;
                     res_in.result_kind = gbsfh_pkg::KIND_CLEAR;
                     res_in.last_row    = 1'b1;
                     state_in           = ST_EMIT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (key_hit) begin
               // hit: bump the group count, fetch the chosen bin
               slot_in               = pend_slot_ff;
               cnt_in                = gbsfh_pkg::sat_inc(ent_rd.count);
               entry_cmd.wr_en       = 1'b1;
               entry_cmd.addr        = pend_slot_ff;
               entry_cmd.wdata       = '{key_width: w_ff, key_height: h_ff,
                                         count: gbsfh_pkg::sat_inc(ent_rd.count)};
               bin_cmd.rd_en         = 1'b1;
               bin_cmd.addr          = gbsfh_pkg::bin_base(pend_slot_ff)
                                       + gbsfh_pkg::BIN_ADDR_W'(bin_ff);
               pend_in               = 1'b0;
               state_in              = ST_BIN_UPD;
            end else if (scan_ff < used_ff) begin
               // advance the scan one slot per cycle
               entry_cmd.rd_en = 1'b1;
               entry_cmd.addr  = scan_ff[gbsfh_pkg::SLOT_W-1:0];
               pend_in         = 1'b1;
               pend_slot_in    = scan_ff[gbsfh_pkg::SLOT_W-1:0];
               scan_in         = scan_ff + 1'b1;
            end else if (used_ff < gbsfh_pkg::USED_W'(gbsfh_pkg::MAX_GROUPS)) begin
               // miss with room left: allocate the next free slot
               slot_in         = used_ff[gbsfh_pkg::SLOT_W-1:0];
               cnt_in          = gbsfh_pkg::COUNT_W'(1);
               entry_cmd.wr_en = 1'b1;
               entry_cmd.addr  = used_ff[gbsfh_pkg::SLOT_W-1:0];
               entry_cmd.wdata = '{key_width: w_ff, key_height: h_ff,
                                   count: gbsfh_pkg::COUNT_W'(1)};
               used_in         = used_ff + 1'b1;
               sweep_in        = '0;
               pend_in         = 1'b0;
               state_in        = ST_FILL;
            end else begin
               // miss on a full table: report and store nothing
               res_in            = '0;
               res_in.result_kind = gbsfh_pkg::KIND_ADD;
               res_in.table_full = 1'b1;
               res_in.bin_number = bin_ff;
               res_in.last_row   = 1'b1;
               pend_in           = 1'b0;
               state_in          = ST_EMIT;
            end
         end

         ST_BIN_UPD: begin
            bin_cmd.wr_en       = 1'b1;
            bin_cmd.addr        = gbsfh_pkg::bin_base(slot_ff)
                                  + gbsfh_pkg::BIN_ADDR_W'(bin_ff);
            bin_cmd.wdata       = bin_new;
            res_in              = '0;
            res_in.result_kind  = gbsfh_pkg::KIND_ADD;
            res_in.group_slot   = slot_ff;
            res_in.group_width  = w_ff;
            res_in.group_height = h_ff;
            res_in.group_total  = cnt_ff;
            res_in.bin_number   = bin_ff;
            res_in.bin_total    = bin_new;
            res_in.entry_valid  = 1'b1;
            res_in.last_row     = 1'b1;
            state_in            = ST_EMIT;
         end

         ST_FILL: begin
            // initialise the new slot's bins, the chosen one to one
            bin_cmd.wr_en = 1'b1;
            bin_cmd.addr  = gbsfh_pkg::bin_base(slot_ff)
                            + gbsfh_pkg::BIN_ADDR_W'(sweep_ff);
            bin_cmd.wdata = (sweep_ff == bin_ff) ? gbsfh_pkg::COUNT_W'(1) : '0;
            if (sweep_ff == gbsfh_pkg::BIN_W'(gbsfh_pkg::LAST_BIN)) begin
               res_in              = '0;
               res_in.result_kind  = gbsfh_pkg::KIND_ADD;
               res_in.group_slot   = slot_ff;
               res_in.is_new_group = 1'b1;
               res_in.group_width  = w_ff;
               res_in.group_height = h_ff;
               res_in.group_total  = cnt_ff;
               res_in.bin_number   = bin_ff;
               res_in.bin_total    = gbsfh_pkg::COUNT_W'(1);
               res_in.entry_valid  = 1'b1;
               res_in.last_row     = 1'b1;
               state_in            = ST_EMIT;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_RD_BIN: begin
            bin_cmd.rd_en = 1'b1;
            bin_cmd.addr  = gbsfh_pkg::bin_base(idx_ff)
                            + gbsfh_pkg::BIN_ADDR_W'(sweep_ff);
            state_in      = ST_RD_OUT;
         end

         ST_RD_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in               = '0;
               rsp_data_in.result_kind   = gbsfh_pkg::KIND_READ;
               rsp_data_in.group_slot    = idx_ff;
               rsp_data_in.bin_number    = sweep_ff;
               rsp_data_in.groups_used   = used_ff;
               rsp_data_in.entry_valid   = rd_valid_ff;
               rsp_data_in.last_row      = (sweep_ff == gbsfh_pkg::BIN_W'(gbsfh_pkg::LAST_BIN));
               if (rd_valid_ff) begin
                  rsp_data_in.group_width  = ent_rd.key_width;
                  rsp_data_in.group_height = ent_rd.key_height;
                  rsp_data_in.group_total  = ent_rd.count;
                  rsp_data_in.bin_total    = bin_rd;
               end
               if (sweep_ff == gbsfh_pkg::BIN_W'(gbsfh_pkg::LAST_BIN)) begin
                  state_in = ST_IDLE;
               end else begin
                  sweep_in = sweep_ff + 1'b1;
                  state_in = ST_RD_BIN;
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (op_ff == gbsfh_pkg::OP_CLEAR) begin
                  used_in                 = '0;
                  rsp_data_in.groups_used = '0;
               end else begin
                  rsp_data_in.groups_used = used_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      w_ff         <= w_in;
      h_ff         <= h_in;
      bin_ff       <= bin_in;
      idx_ff       <= idx_in;
      rd_valid_ff  <= rd_valid_in;
      scan_ff      <= scan_in;
      pend_slot_ff <= pend_slot_in;
      slot_ff      <= slot_in;
      cnt_ff       <= cnt_in;
      sweep_ff     <= sweep_in;
      res_ff       <= res_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req.ready   = req_ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // the group count never passes the table size
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= gbsfh_pkg::USED_W'(gbsfh_pkg::MAX_GROUPS))
      else $error("group count beyond table size");

   // a full report only comes from a table with every slot taken
   a_full_needs_full_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.table_full
      |-> used_ff == gbsfh_pkg::USED_W'(gbsfh_pkg::MAX_GROUPS))
      else $error("table full reported with free slots");

   // a freshly allocated group holds exactly one item in one bin
   a_new_group_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.is_new_group
      |-> rsp_data_ff.group_total == gbsfh_pkg::COUNT_W'(1)
          && rsp_data_ff.bin_total == gbsfh_pkg::COUNT_W'(1))
      else $error("new group with wrong counts");

   // any accepted command other than the unused opcode starts work
   a_command_starts: assert property (@(posedge clock) disable iff (reset)
      req.valid && req_ready && req.payload.opcode != gbsfh_pkg::OP_NONE
      |=> state_ff != ST_IDLE)
      else $error("accepted command left the sequencer idle");

endmodule
